// ===== sv/mer_pkg.sv =====
// ----------------------------------------------------------------------------
// mer_pkg
// Shared types, field layout constants and table lookup functions for the
// mesh edge ring ordering block.
// ----------------------------------------------------------------------------
package mer_pkg;

    localparam int VID_W       = 32;
    localparam int TBL_EC_W    = 24;
    localparam int TBL_OE_W    = 18;
    localparam int CFG_IDX_W   = 8;
    localparam int CFG_DATA_W  = 24;
    localparam int CNT_W       = 8;
    localparam int POS_W       = 4;
    localparam int STAT_W      = 2;
    localparam int LEDGE_W     = 3;

    localparam int IN_TDATA_W  = 200;
    localparam int OUT_TDATA_W = 48;
    localparam int OUT_TUSER_W = STAT_W;

    localparam logic [TBL_EC_W-1:0] EC_TABLE_RST = 24'd15581844;
    localparam logic [TBL_OE_W-1:0] OE_TABLE_RST = 18'd8989;

    localparam logic [CFG_IDX_W-1:0] REG_EDGE_CORNER   = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_OPPOSITE_EDGE = 8'd1;

    localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
    localparam logic [STAT_W-1:0] ST_TOO_LARGE = 2'd1;
    localparam logic [STAT_W-1:0] ST_TOO_SMALL = 2'd2;
    localparam logic [STAT_W-1:0] ST_BROKEN    = 2'd3;

    typedef logic [3:0][VID_W-1:0] corners_t;

    typedef struct packed {
        logic [VID_W-1:0] finish_v;
        logic [VID_W-1:0] start_v;
    } pair_t;

    function automatic logic [1:0] corner_of(input logic [TBL_EC_W-1:0] tbl,
                                             input logic [LEDGE_W-1:0] e,
                                             input logic which);
        logic [3:0] nib;
        nib = 4'b0000;
        if (e < 3'd6)
        begin
            nib = tbl[{e, 2'b00} +: 4];
        end
        return which ? nib[3:2] : nib[1:0];
    endfunction

    function automatic logic [LEDGE_W-1:0] opposite_of(input logic [TBL_OE_W-1:0] tbl,
                                                       input logic [LEDGE_W-1:0] e);
        logic [LEDGE_W-1:0] o;
        o = '0;
        if (e < 3'd6)
        begin
            o = tbl[5'(e) * 5'd3 +: 3];
        end
        return o;
    endfunction

endpackage

// ===== sv/mer_pair_sel.sv =====
// ----------------------------------------------------------------------------
// mer_pair_sel
// Finds the edge opposite the central edge of one tetrahedron and orients it
// against the start vertex of the central edge.
// ----------------------------------------------------------------------------
module mer_pair_sel (
    input  logic [mer_pkg::TBL_EC_W-1:0] ec_table,
    input  logic [mer_pkg::TBL_OE_W-1:0] oe_table,
    input  mer_pkg::corners_t            corners,
    input  logic [mer_pkg::LEDGE_W-1:0]  local_edge,
    input  logic [mer_pkg::VID_W-1:0]    central_start,
    output mer_pkg::pair_t               pair
);
    import mer_pkg::*;

    logic                align;
    logic [LEDGE_W-1:0]  opp;
    logic [1:0]          c_first;

    always_comb
    begin
        c_first       = corner_of(ec_table, local_edge, 1'b0);
        align         = (corners[c_first] != central_start);
        opp           = opposite_of(oe_table, local_edge);
        pair.start_v  = corners[corner_of(ec_table, opp, align)];
        pair.finish_v = corners[corner_of(ec_table, opp, ~align)];
    end

endmodule

// ===== sv/mesh_edge_ring_order.sv =====
// ----------------------------------------------------------------------------
// mesh_edge_ring_order
// Items that are not the last of a ring leave the block idle. The last item
// of a legal-size ring starts a chaining pass with one shared compare unit:
// S_RD0 and S_GET0 fetch the first pair, S_SRCH and S_CMP make each compare,
// S_GETN and S_SW2 each swap, S_ERD and S_EMIT each emitted vertex. A status
// result goes via S_STAT to the output register. Reset restores the tables
// and clears the counters at once; the pair store is not cleared.
// ----------------------------------------------------------------------------
module mesh_edge_ring_order #(
    parameter int MAX_RING = 7
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // edge_end0, edge_end1, tet_corner0..3, local_edge, zero padding
    input  logic [mer_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
    // last_use
    input  logic                            s_axis_tlast,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // ring_vertex, position, ring_count, zero padding
    output logic [mer_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    // status
    output logic [mer_pkg::OUT_TUSER_W-1:0] m_axis_tuser,
    // last
    output logic                            m_axis_tlast,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [mer_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [mer_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import mer_pkg::*;

    localparam int AW = (MAX_RING > 1) ? $clog2(MAX_RING) : 1;
    localparam int CW = $clog2(MAX_RING + 1);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_STAT = 4'd1;
    localparam logic [3:0] S_RD0  = 4'd2;
    localparam logic [3:0] S_GET0 = 4'd3;
    localparam logic [3:0] S_SRCH = 4'd4;
    localparam logic [3:0] S_CMP  = 4'd5;
    localparam logic [3:0] S_GETN = 4'd6;
    localparam logic [3:0] S_SW2  = 4'd7;
    localparam logic [3:0] S_ERD  = 4'd8;
    localparam logic [3:0] S_EMIT = 4'd9;

    logic [3:0]          state_reg, state_next;
    logic [TBL_EC_W-1:0] ec_reg, ec_next;
    logic [TBL_OE_W-1:0] oe_reg, oe_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic [CNT_W-1:0]    n_reg, n_next;
    logic [VID_W-1:0]    cstart_reg, cstart_next;
    logic [STAT_W-1:0]   stat_reg, stat_next;
    logic [CW-1:0]       i_reg, i_next;
    logic [CW-1:0]       j_reg, j_next;
    logic [CW-1:0]       k_reg, k_next;
    logic [VID_W-1:0]    endv_reg, endv_next;
    pair_t               pj_reg, pj_next;
    pair_t               pn_reg, pn_next;

    logic                out_valid_reg, out_valid_next;
    logic [VID_W-1:0]    out_vtx_reg, out_vtx_next;
    logic [POS_W-1:0]    out_pos_reg, out_pos_next;
    logic [CNT_W-1:0]    out_cnt_reg, out_cnt_next;
    logic [STAT_W-1:0]   out_stat_reg, out_stat_next;
    logic                out_last_reg, out_last_next;

    pair_t               mem [MAX_RING];
    pair_t               rd_q;
    logic [AW-1:0]       rd_addr;
    logic                mem_we;
    logic [AW-1:0]       mem_waddr;
    pair_t               mem_wdata;

    logic                accept;
    logic                out_free;
    logic [CNT_W-1:0]    count_inc;
    logic [VID_W-1:0]    cstart_use;
    logic [CW-1:0]       ip1, ip2, jp1, kp1;
    corners_t            corners;
    pair_t               new_pair;

    assign cfg_ready     = 1'b1;
    assign s_axis_tready = (state_reg == S_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign out_free      = !out_valid_reg || m_axis_tready;
    assign count_inc     = (count_reg == 8'hFF) ? count_reg : count_reg + 8'd1;
    assign cstart_use    = (count_reg == '0) ? s_axis_tdata[31:0] : cstart_reg;
    assign corners       = s_axis_tdata[191:64];
    assign ip1           = i_reg + 1'b1;
    assign ip2           = i_reg + CW'(2);
    assign jp1           = j_reg + 1'b1;
    assign kp1           = k_reg + 1'b1;

    mer_pair_sel u_pair_sel (
        .ec_table      (ec_reg),
        .oe_table      (oe_reg),
        .corners       (corners),
        .local_edge    (s_axis_tdata[194:192]),
        .central_start (cstart_use),
        .pair          (new_pair)
    );

    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = count_reg[AW-1:0];
        mem_wdata = new_pair;
        rd_addr   = '0;
        case (state_reg)
            S_IDLE:
            begin
                mem_we = accept && (count_reg < 8'(MAX_RING));
            end
            S_SRCH:
            begin
                rd_addr = j_reg[AW-1:0];
            end
            S_CMP:
            begin
                rd_addr = ip1[AW-1:0];
            end
            S_GETN:
            begin
                mem_we    = 1'b1;
                mem_waddr = ip1[AW-1:0];
                mem_wdata = pj_reg;
            end
            S_SW2:
            begin
                mem_we    = 1'b1;
                mem_waddr = j_reg[AW-1:0];
                mem_wdata = pn_reg;
            end
            S_ERD, S_EMIT:
            begin
                rd_addr = k_reg[AW-1:0];
            end
            default:
            begin
                rd_addr = '0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        rd_q <= mem[rd_addr];
    end

    always_comb
    begin
        state_next     = state_reg;
        ec_next        = ec_reg;
        oe_next        = oe_reg;
        count_next     = count_reg;
        n_next         = n_reg;
        cstart_next    = cstart_reg;
        stat_next      = stat_reg;
        i_next         = i_reg;
        j_next         = j_reg;
        k_next         = k_reg;
        endv_next      = endv_reg;
        pj_next        = pj_reg;
        pn_next        = pn_reg;
        out_valid_next = out_valid_reg && !m_axis_tready;
        out_vtx_next   = out_vtx_reg;
        out_pos_next   = out_pos_reg;
        out_cnt_next   = out_cnt_reg;
        out_stat_next  = out_stat_reg;
        out_last_next  = out_last_reg;

        if (cfg_valid && cfg_ready)
        begin
            if (cfg_index == REG_EDGE_CORNER)
            begin
                ec_next = cfg_data[TBL_EC_W-1:0];
            end
            else if (cfg_index == REG_OPPOSITE_EDGE)
            begin
                oe_next = cfg_data[TBL_OE_W-1:0];
            end
        end

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    cstart_next = cstart_use;
                    count_next  = count_inc;
                    if (s_axis_tlast)
                    begin
                        count_next = '0;
                        n_next     = count_inc;
                        i_next     = '0;
                        if (count_inc > 8'(MAX_RING))
                        begin
                            stat_next  = ST_TOO_LARGE;
                            state_next = S_STAT;
                        end
                        else if (count_inc < 8'd3)
                        begin
                            stat_next  = ST_TOO_SMALL;
                            state_next = S_STAT;
                        end
                        else
                        begin
                            state_next = S_RD0;
                        end
                    end
                end
            end
            S_RD0:
            begin
                state_next = S_GET0;
            end
            S_GET0:
            begin
                endv_next  = rd_q.finish_v;
                j_next     = CW'(1);
                state_next = S_SRCH;
            end
            S_SRCH:
            begin
                state_next = S_CMP;
            end
            S_CMP:
            begin
                if (rd_q.start_v == endv_reg)
                begin
                    pj_next    = rd_q;
                    state_next = S_GETN;
                end
                else if (8'(jp1) == n_reg)
                begin
                    stat_next  = ST_BROKEN;
                    state_next = S_STAT;
                end
                else
                begin
                    j_next     = jp1;
                    state_next = S_SRCH;
                end
            end
            S_GETN:
            begin
                pn_next    = rd_q;
                state_next = S_SW2;
            end
            S_SW2:
            begin
                endv_next = pj_reg.finish_v;
                i_next    = ip1;
                if (8'(ip2) < n_reg)
                begin
                    j_next     = ip2;
                    state_next = S_SRCH;
                end
                else
                begin
                    k_next     = '0;
                    state_next = S_ERD;
                end
            end
            S_ERD:
            begin
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_vtx_next   = rd_q.start_v;
                    out_pos_next   = POS_W'(k_reg);
                    out_cnt_next   = n_reg;
                    out_stat_next  = ST_OK;
                    out_last_next  = (8'(kp1) == n_reg);
                    k_next         = kp1;
                    state_next     = (8'(kp1) == n_reg) ? S_IDLE : S_ERD;
                end
            end
            S_STAT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_vtx_next   = '0;
                    out_pos_next   = '0;
                    out_cnt_next   = n_reg;
                    out_stat_next  = stat_reg;
                    out_last_next  = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            ec_reg        <= EC_TABLE_RST;
            oe_reg        <= OE_TABLE_RST;
            count_reg     <= '0;
            n_reg         <= '0;
            cstart_reg    <= '0;
            stat_reg      <= ST_OK;
            i_reg         <= '0;
            j_reg         <= '0;
            k_reg         <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            ec_reg        <= ec_next;
            oe_reg        <= oe_next;
            count_reg     <= count_next;
            n_reg         <= n_next;
            cstart_reg    <= cstart_next;
            stat_reg      <= stat_next;
            i_reg         <= i_next;
            j_reg         <= j_next;
            k_reg         <= k_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        endv_reg     <= endv_next;
        pj_reg       <= pj_next;
        pn_reg       <= pn_next;
        out_vtx_reg  <= out_vtx_next;
        out_pos_reg  <= out_pos_next;
        out_cnt_reg  <= out_cnt_next;
        out_stat_reg <= out_stat_next;
        out_last_reg <= out_last_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {4'b0000, out_cnt_reg, out_pos_reg, out_vtx_reg};
    assign m_axis_tuser  = out_stat_reg;
    assign m_axis_tlast  = out_last_reg;

endmodule

// ===== sv/mer_checker.sv =====
// ----------------------------------------------------------------------------
// mer_checker
// Port-level checks of the ring ordering block, bound to its top level.
// ----------------------------------------------------------------------------
module mer_checker (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            s_axis_tvalid,
    input logic                            s_axis_tready,
    input logic                            s_axis_tlast,
    input logic                            m_axis_tvalid,
    input logic                            m_axis_tready,
    input logic [mer_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    input logic [mer_pkg::OUT_TUSER_W-1:0] m_axis_tuser,
    input logic                            m_axis_tlast
);
    import mer_pkg::*;

    // A stalled result must hold its contents.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
        m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("result changed while stalled");

    // A status result is the only result of its ring and carries no vertex.
    a_status_form: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (m_axis_tuser != ST_OK) |->
        m_axis_tlast && (m_axis_tdata[35:0] == 36'd0))
        else $error("malformed status result");

    // The final vertex of an ordered ring sits at position ring_count - 1.
    a_last_pos: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tlast && (m_axis_tuser == ST_OK) |->
        m_axis_tdata[35:32] == 4'(m_axis_tdata[43:36] - 8'd1))
        else $error("final vertex position does not match ring count");

    // After the last item of a ring the block stops taking items to order it.
    a_last_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready && s_axis_tlast |=> !s_axis_tready)
        else $error("item taken right after the last item of a ring");

endmodule

bind mesh_edge_ring_order mer_checker u_mer_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);

// ===== tb/mesh_edge_ring_order_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mesh_edge_ring_order_test
// Drives rings of tetrahedron items into the edge ring ordering block and
// checks every ordered vertex and status result against a predictor kept in
// the bench. Rings are mostly well formed with random vertex ids and random
// arrival order, mixed with broken, short, oversized and odd-edge rings,
// under several corner and opposite edge table settings.
// ----------------------------------------------------------------------------
module mesh_edge_ring_order_test;

    import mer_pkg::*;

    localparam int RING_CAP      = 7;
    localparam int PHASE_ITEMS   = 16;
    localparam int SETTLE_CYCLES = 120;
    localparam int QUIET_LIMIT   = 3000;

    typedef struct packed {
        logic                   lst;
        logic [LEDGE_W-1:0]     le;
        corners_t               corners;
        logic [VID_W-1:0]       end1;
        logic [VID_W-1:0]       end0;
    } tet_item_t;

    typedef struct packed {
        logic [VID_W-1:0]  vtx;
        logic [POS_W-1:0]  pos;
        logic [CNT_W-1:0]  cnt;
        logic [STAT_W-1:0] st;
        logic              lst;
    } ring_result_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
    logic                   s_axis_tlast = 1'b0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic [OUT_TUSER_W-1:0] m_axis_tuser;
    logic                   m_axis_tlast;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_IDX_W-1:0]   cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;

    tet_item_t    tet_queue[$];
    ring_result_t ring_expect[$];
    tet_item_t    cur_tet;

    logic [TBL_EC_W-1:0] ec_tbl = EC_TABLE_RST;
    logic [TBL_OE_W-1:0] oe_tbl = OE_TABLE_RST;
    logic [VID_W-1:0]    pair_from [RING_CAP];
    logic [VID_W-1:0]    pair_to [RING_CAP];
    logic [VID_W-1:0]    hub_start = '0;
    int unsigned         tet_count = 0;

    bit          in_fire = 1'b0;
    bit          out_fire = 1'b0;
    bit          calm = 1'b0;
    int unsigned feed_gap = 0;
    int unsigned sink_hold = 0;
    int unsigned quiet_cycles = 0;
    int unsigned err_count = 0;

    mesh_edge_ring_order #(
        .MAX_RING(RING_CAP)
    ) u_top (
        .clk(clk),
        .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .s_axis_tlast(s_axis_tlast),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .m_axis_tuser(m_axis_tuser),
        .m_axis_tlast(m_axis_tlast),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always #6 clk = ~clk;

    function automatic int unsigned pick_gap();
        int unsigned r;
        if (calm)
        begin
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 60)
        begin
            return 0;
        end
        if (r < 92)
        begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 30);
    endfunction

    // Edges and opposites past the end of a table read zero bits.
    function automatic logic [1:0] tbl_corner(input logic [LEDGE_W-1:0] e, input logic hi);
        logic [31:0] wide;
        logic [3:0]  nib;
        wide = {8'h00, ec_tbl};
        nib = wide[4*e +: 4];
        return hi ? nib[3:2] : nib[1:0];
    endfunction

    function automatic logic [LEDGE_W-1:0] tbl_opp(input logic [LEDGE_W-1:0] e);
        logic [23:0] wide;
        wide = {6'h00, oe_tbl};
        return wide[3*e +: 3];
    endfunction

    function automatic void push_result(input logic [VID_W-1:0] v, input int unsigned p,
                                        input int unsigned c, input logic [STAT_W-1:0] s,
                                        input logic l);
        ring_result_t r;
        r.vtx = v;
        r.pos = POS_W'(p);
        r.cnt = CNT_W'(c);
        r.st = s;
        r.lst = l;
        ring_expect.push_back(r);
    endfunction

    function automatic void order_ring_step(input tet_item_t t);
        logic [LEDGE_W-1:0] op;
        logic               flip;
        logic [VID_W-1:0]   pa;
        logic [VID_W-1:0]   pb;
        logic [VID_W-1:0]   tmp;
        int unsigned        n;
        int unsigned        i;
        int unsigned        j;
        int unsigned        hit;
        bit                 found;
        if (tet_count == 0)
        begin
            hub_start = t.end0;
        end
        flip = (t.corners[tbl_corner(t.le, 1'b0)] != hub_start);
        op = tbl_opp(t.le);
        pa = t.corners[tbl_corner(op, flip)];
        pb = t.corners[tbl_corner(op, ~flip)];
        if (tet_count < RING_CAP)
        begin
            pair_from[tet_count] = pa;
            pair_to[tet_count] = pb;
        end
        if (tet_count < 255)
        begin
            tet_count++;
        end
        if (!t.lst)
        begin
            return;
        end
        n = tet_count;
        tet_count = 0;
        if (n > RING_CAP)
        begin
            push_result('0, 0, n, ST_TOO_LARGE, 1'b1);
            return;
        end
        if (n < 3)
        begin
            push_result('0, 0, n, ST_TOO_SMALL, 1'b1);
            return;
        end
        for (i = 0; i + 1 < n; i++)
        begin
            found = 1'b0;
            hit = 0;
            for (j = i + 1; j < n && !found; j++)
            begin
                if (pair_from[j] == pair_to[i])
                begin
                    found = 1'b1;
                    hit = j;
                end
            end
            if (!found)
            begin
                push_result('0, 0, n, ST_BROKEN, 1'b1);
                return;
            end
            tmp = pair_from[hit];
            pair_from[hit] = pair_from[i + 1];
            pair_from[i + 1] = tmp;
            tmp = pair_to[hit];
            pair_to[hit] = pair_to[i + 1];
            pair_to[i + 1] = tmp;
        end
        for (i = 0; i < n; i++)
        begin
            push_result(pair_from[i], i, n, ST_OK, i + 1 == n);
        end
    endfunction

    // Each item of a well-formed ring carries the pair from its vertex to the
    // next ring vertex; the items are sent in a shuffled order.
    task automatic push_ring(input logic [VID_W-1:0] a, input logic [VID_W-1:0] b,
                             input logic [VID_W-1:0] verts[$], input bit wild,
                             input bit corrupt);
        tet_item_t          t;
        int unsigned        order[$];
        int unsigned        n;
        int unsigned        i;
        int unsigned        j;
        int unsigned        k;
        int unsigned        tmp;
        logic [VID_W-1:0]   hs;
        logic [VID_W-1:0]   hx;
        logic [VID_W-1:0]   nxt;
        logic [LEDGE_W-1:0] le;
        logic [LEDGE_W-1:0] op;
        logic [1:0]         ce0;
        logic [1:0]         ce1;
        logic [1:0]         o0;
        logic [1:0]         o1;
        bit                 flip;
        n = verts.size();
        for (i = 0; i < n; i++)
        begin
            order.push_back(i);
        end
        for (i = n - 1; i > 0; i--)
        begin
            j = $urandom_range(0, i);
            tmp = order[i];
            order[i] = order[j];
            order[j] = tmp;
        end
        flip = 1'($urandom_range(0, 1));
        hs = flip ? b : a;
        hx = flip ? a : b;
        for (i = 0; i < n; i++)
        begin
            k = order[i];
            nxt = (corrupt && i == 0) ? VID_W'($urandom) : verts[(k + 1) % n];
            if (wild)
            begin
                le = (i == 0) ? 3'd7 : (i == 1) ? 3'd6 : LEDGE_W'($urandom_range(0, 7));
            end
            else
            begin
                le = LEDGE_W'($urandom_range(0, 5));
            end
            op = tbl_opp(le);
            ce0 = tbl_corner(le, 1'b0);
            ce1 = tbl_corner(le, 1'b1);
            o0 = tbl_corner(op, 1'b0);
            o1 = tbl_corner(op, 1'b1);
            t.end0 = (i == 0) ? hs : VID_W'($urandom);
            t.end1 = (i == 0) ? hx : VID_W'($urandom);
            for (j = 0; j < 4; j++)
            begin
                t.corners[j] = $urandom;
            end
            if ($urandom_range(0, 1))
            begin
                t.corners[ce0] = hx;
                t.corners[ce1] = hs;
                t.corners[o1] = verts[k];
                t.corners[o0] = nxt;
            end
            else
            begin
                t.corners[ce0] = hs;
                t.corners[ce1] = hx;
                t.corners[o0] = verts[k];
                t.corners[o1] = nxt;
            end
            t.le = le;
            t.lst = (i + 1 == n);
            tet_queue.push_back(t);
        end
    endtask

    task automatic random_ring(input int unsigned n, input bit wild, input bit corrupt);
        logic [VID_W-1:0] verts[$];
        int unsigned      i;
        for (i = 0; i < n; i++)
        begin
            verts.push_back($urandom);
        end
        push_ring($urandom, $urandom, verts, wild, corrupt);
    endtask

    task automatic fill_random(input int unsigned budget);
        int unsigned added;
        int unsigned r;
        int unsigned n;
        bit          wild;
        bit          corrupt;
        added = 0;
        while (added < budget)
        begin
            r = $urandom_range(0, 99);
            wild = (r >= 91);
            corrupt = (r >= 65 && r < 75);
            if (r >= 75 && r < 83)
            begin
                n = $urandom_range(1, 2);
            end
            else if (r >= 83 && r < 91)
            begin
                n = $urandom_range(RING_CAP + 1, RING_CAP + 5);
            end
            else
            begin
                n = $urandom_range(3, RING_CAP);
            end
            random_ring(n, wild, corrupt);
            added += n;
        end
    endtask

    // A relabeling of the default corners keeps every tetrahedron valid.
    function automatic logic [TBL_EC_W-1:0] permuted_corner_table();
        logic [1:0]          perm [4];
        logic [1:0]          tmp;
        logic [1:0]          a0;
        logic [1:0]          a1;
        logic [TBL_EC_W-1:0] base;
        logic [TBL_EC_W-1:0] t;
        logic [3:0]          nib;
        int unsigned         i;
        int unsigned         j;
        base = EC_TABLE_RST;
        t = '0;
        for (i = 0; i < 4; i++)
        begin
            perm[i] = 2'(i);
        end
        for (i = 3; i > 0; i--)
        begin
            j = $urandom_range(0, i);
            tmp = perm[i];
            perm[i] = perm[j];
            perm[j] = tmp;
        end
        for (i = 0; i < 6; i++)
        begin
            nib = base[4*i +: 4];
            a0 = perm[nib[1:0]];
            a1 = perm[nib[3:2]];
            t[4*i +: 4] = $urandom_range(0, 1) ? {a0, a1} : {a1, a0};
        end
        return t;
    endfunction

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        while (!cfg_ready)
        begin
            @(posedge clk);
        end
        if (idx == REG_EDGE_CORNER)
        begin
            ec_tbl = val[TBL_EC_W-1:0];
        end
        else if (idx == REG_OPPOSITE_EDGE)
        begin
            oe_tbl = val[TBL_OE_W-1:0];
        end
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic settle();
        while (tet_queue.size() != 0 || s_axis_tvalid || ring_expect.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic report(input string msg);
        $display("ERROR at %0t: %s", $time, msg);
        err_count++;
    endtask

    task automatic cmp_field(input string name, input logic [31:0] got, input logic [31:0] want);
        if (got !== want)
        begin
            report($sformatf("%s is %0h, expected %0h", name, got, want));
        end
    endtask

    task automatic check_result();
        ring_result_t got;
        ring_result_t want;
        got.vtx = m_axis_tdata[31:0];
        got.pos = m_axis_tdata[35:32];
        got.cnt = m_axis_tdata[43:36];
        got.st = m_axis_tuser;
        got.lst = m_axis_tlast;
        if (ring_expect.size() == 0)
        begin
            report($sformatf("unexpected result, vertex %0h status %0d", got.vtx, got.st));
            return;
        end
        want = ring_expect.pop_front();
        cmp_field("ring_vertex", got.vtx, want.vtx);
        cmp_field("position", 32'(got.pos), 32'(want.pos));
        cmp_field("ring_count", 32'(got.cnt), 32'(want.cnt));
        cmp_field("status", 32'(got.st), 32'(want.st));
        cmp_field("last", 32'(got.lst), 32'(want.lst));
    endtask

    always @(negedge clk)
    begin : feed
        logic nv;
        nv = s_axis_tvalid;
        if (!rst_n)
        begin
            nv = 1'b0;
        end
        else if (!s_axis_tvalid || in_fire)
        begin
            if (feed_gap > 0)
            begin
                feed_gap--;
                nv = 1'b0;
            end
            else if (tet_queue.size() > 0)
            begin
                cur_tet = tet_queue.pop_front();
                s_axis_tdata <= {5'b0, cur_tet.le, cur_tet.corners, cur_tet.end1, cur_tet.end0};
                s_axis_tlast <= cur_tet.lst;
                nv = 1'b1;
                feed_gap = pick_gap();
            end
            else
            begin
                nv = 1'b0;
            end
        end
        s_axis_tvalid <= nv;
    end

    always @(negedge clk)
    begin : sink
        if (sink_hold > 0)
        begin
            m_axis_tready <= 1'b0;
            sink_hold--;
        end
        else
        begin
            m_axis_tready <= 1'b1;
            sink_hold = pick_gap();
        end
    end

    always @(posedge clk)
    begin : monitor
        in_fire = rst_n && s_axis_tvalid && s_axis_tready;
        out_fire = rst_n && m_axis_tvalid && m_axis_tready;
        if (in_fire)
        begin
            order_ring_step(cur_tet);
        end
        if (out_fire)
        begin
            check_result();
        end
        if (in_fire || out_fire || (cfg_valid && cfg_ready))
        begin
            quiet_cycles = 0;
        end
        else
        begin
            quiet_cycles++;
        end
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial
    begin : stimulus
        logic [VID_W-1:0] edge_verts[$];
        int unsigned      ph;
        repeat (7) @(negedge clk);
        rst_n = 1'b1;

        // The directed rings run on the reset tables.
        edge_verts = '{32'hFFFF_FFFE, 32'h0000_0001, 32'h8000_0000};
        push_ring(32'h0000_0000, 32'hFFFF_FFFF, edge_verts, 1'b0, 1'b0);
        random_ring(RING_CAP, 1'b0, 1'b0);
        random_ring(1, 1'b0, 1'b0);
        random_ring(2, 1'b0, 1'b0);
        random_ring(RING_CAP + 1, 1'b0, 1'b0);
        random_ring(3, 1'b1, 1'b0);
        random_ring(3, 1'b0, 1'b1);
        settle();

        for (ph = 0; ph < 8; ph++)
        begin
            case (ph)
                0:
                begin
                    write_reg(REG_EDGE_CORNER, 24'hFF_FFFF);
                    write_reg(REG_OPPOSITE_EDGE, 24'h03_FFFF);
                end
                1:
                begin
                    write_reg(REG_EDGE_CORNER, 24'h00_0000);
                    write_reg(REG_OPPOSITE_EDGE, 24'h00_0000);
                end
                3:
                begin
                    write_reg(REG_EDGE_CORNER, CFG_DATA_W'($urandom));
                    write_reg(REG_OPPOSITE_EDGE, CFG_DATA_W'($urandom_range(0, 18'h3_FFFF)));
                end
                5:
                begin
                    write_reg(REG_EDGE_CORNER, CFG_DATA_W'($urandom));
                    write_reg(REG_OPPOSITE_EDGE, CFG_DATA_W'(OE_TABLE_RST));
                end
                7:
                begin
                    write_reg(REG_EDGE_CORNER, EC_TABLE_RST);
                    write_reg(REG_OPPOSITE_EDGE, CFG_DATA_W'(OE_TABLE_RST));
                end
                default:
                begin
                    write_reg(REG_EDGE_CORNER, permuted_corner_table());
                    write_reg(REG_OPPOSITE_EDGE, CFG_DATA_W'(OE_TABLE_RST));
                end
            endcase
            calm = (ph == 4);
            if (ph == 6)
            begin
                random_ring(257, 1'b0, 1'b0);
            end
            fill_random(PHASE_ITEMS / 2);
            // The sender holds off here until every pending result is out.
            settle();
            fill_random(PHASE_ITEMS / 2);
            settle();
        end

        if (err_count == 0)
        begin
            $display("CHECK OK");
        end
        else
        begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
